// ===== design/nirfd_pkg.sv =====
// ----------------------------------------------------------------------------
// nirfd_pkg
// Shared types and constants for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package nirfd_pkg;

   localparam int DURATION_BITS_DEF = 16;

   // csr map
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CFG_W       = 16;
   localparam int TIMEOUT_W   = 2;

   localparam logic [2:0] REG_LEADER_MARK_MIN  = 3'd0;
   localparam logic [2:0] REG_LEADER_MARK_MAX  = 3'd1;
   localparam logic [2:0] REG_LEADER_SPACE_MIN = 3'd2;
   localparam logic [2:0] REG_LEADER_SPACE_MAX = 3'd3;
   localparam logic [2:0] REG_BIT_PERIOD_MIN   = 3'd4;
   localparam logic [2:0] REG_BIT_PERIOD_MAX   = 3'd5;
   localparam logic [2:0] REG_ONE_THRESHOLD    = 3'd6;
   localparam logic [2:0] REG_TIMEOUT_TICKS    = 3'd7;

   localparam logic [CFG_W-1:0]     RST_LEADER_MARK_MIN  = 16'd8000;
   localparam logic [CFG_W-1:0]     RST_LEADER_MARK_MAX  = 16'd10000;
   localparam logic [CFG_W-1:0]     RST_LEADER_SPACE_MIN = 16'd3500;
   localparam logic [CFG_W-1:0]     RST_LEADER_SPACE_MAX = 16'd5500;
   localparam logic [CFG_W-1:0]     RST_BIT_PERIOD_MIN   = 16'd1000;
   localparam logic [CFG_W-1:0]     RST_BIT_PERIOD_MAX   = 16'd2400;
   localparam logic [CFG_W-1:0]     RST_ONE_THRESHOLD    = 16'd1700;
   localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS    = 2'd2;

   // fixed repeat-code windows (open intervals)
   localparam logic [CFG_W-1:0] REP_SPACE_MIN = 16'd1700;
   localparam logic [CFG_W-1:0] REP_SPACE_MAX = 16'd2400;
   localparam logic [CFG_W-1:0] REP_BURST_MIN = 16'd500;
   localparam logic [CFG_W-1:0] REP_BURST_MAX = 16'd650;

   localparam int         FRAME_BITS  = 32;
   localparam int         BCNT_W      = 6;
   localparam logic [8:0] CSUM_TARGET = 9'h0ff;

   // input kinds
   localparam logic CMD_CAPTURE  = 1'b0;
   localparam logic CMD_OVERFLOW = 1'b1;

   // leader / repeat phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_MARK  = 2'd1;
   localparam logic [1:0] PH_SPACE = 2'd2;
   localparam logic [1:0] PH_BURST = 2'd3;

   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic [CFG_W-1:0]     leader_mark_min;
      logic [CFG_W-1:0]     leader_mark_max;
      logic [CFG_W-1:0]     leader_space_min;
      logic [CFG_W-1:0]     leader_space_max;
      logic [CFG_W-1:0]     bit_period_min;
      logic [CFG_W-1:0]     bit_period_max;
      logic [CFG_W-1:0]     one_threshold;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [7:0] command_inv_byte;
      logic [7:0] command_byte;
      logic [7:0] address_inv_byte;
      logic [7:0] address_byte;
      logic       key_held;
      logic       released;
      logic       repeat_seen;
      logic       frame_ready;
      logic       capture_rising;
   } res_type;

endpackage

// ===== design/nirfd_csr.sv =====
// ----------------------------------------------------------------------------
// nirfd_csr
// APB-style register file holding the decoder timing windows.
// ----------------------------------------------------------------------------
module nirfd_csr
   import nirfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LEADER_MARK_MIN:  cfg_in.leader_mark_min  = csr_pwdata[CFG_W-1:0];
            REG_LEADER_MARK_MAX:  cfg_in.leader_mark_max  = csr_pwdata[CFG_W-1:0];
            REG_LEADER_SPACE_MIN: cfg_in.leader_space_min = csr_pwdata[CFG_W-1:0];
            REG_LEADER_SPACE_MAX: cfg_in.leader_space_max = csr_pwdata[CFG_W-1:0];
            REG_BIT_PERIOD_MIN:   cfg_in.bit_period_min   = csr_pwdata[CFG_W-1:0];
            REG_BIT_PERIOD_MAX:   cfg_in.bit_period_max   = csr_pwdata[CFG_W-1:0];
            REG_ONE_THRESHOLD:    cfg_in.one_threshold    = csr_pwdata[CFG_W-1:0];
            REG_TIMEOUT_TICKS:    cfg_in.timeout_ticks    = csr_pwdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LEADER_MARK_MIN:  csr_prdata = CSR_DATA_W'(cfg_ff.leader_mark_min);
         REG_LEADER_MARK_MAX:  csr_prdata = CSR_DATA_W'(cfg_ff.leader_mark_max);
         REG_LEADER_SPACE_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.leader_space_min);
         REG_LEADER_SPACE_MAX: csr_prdata = CSR_DATA_W'(cfg_ff.leader_space_max);
         REG_BIT_PERIOD_MIN:   csr_prdata = CSR_DATA_W'(cfg_ff.bit_period_min);
         REG_BIT_PERIOD_MAX:   csr_prdata = CSR_DATA_W'(cfg_ff.bit_period_max);
         REG_ONE_THRESHOLD:    csr_prdata = CSR_DATA_W'(cfg_ff.one_threshold);
         REG_TIMEOUT_TICKS:    csr_prdata = CSR_DATA_W'(cfg_ff.timeout_ticks);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark_min  <= RST_LEADER_MARK_MIN;
         cfg_ff.leader_mark_max  <= RST_LEADER_MARK_MAX;
         cfg_ff.leader_space_min <= RST_LEADER_SPACE_MIN;
         cfg_ff.leader_space_max <= RST_LEADER_SPACE_MAX;
         cfg_ff.bit_period_min   <= RST_BIT_PERIOD_MIN;
         cfg_ff.bit_period_max   <= RST_BIT_PERIOD_MAX;
         cfg_ff.one_threshold    <= RST_ONE_THRESHOLD;
         cfg_ff.timeout_ticks    <= RST_TIMEOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/nirfd_decode.sv =====
// ----------------------------------------------------------------------------
// nirfd_decode
// Frame state and single-pass decode of one registered beat.
// ----------------------------------------------------------------------------
module nirfd_decode
   import nirfd_pkg::*;
#(
   parameter int DURATION_BITS = DURATION_BITS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     step,
   input  logic                     cmd,
   input  logic [DURATION_BITS-1:0] duration,
   output res_type                  res
);

   // compare width covers both the capture and the 16-bit windows
   localparam int CW = (DURATION_BITS > CFG_W) ? DURATION_BITS : CFG_W;

   logic [1:0]        leader_phase_ff, leader_phase_in;
   logic              in_data_ff, in_data_in;
   logic [BCNT_W-1:0] bit_count_ff, bit_count_in;
   logic [31:0]       shift_word_ff, shift_word_in;
   logic [1:0]        repeat_phase_ff, repeat_phase_in;
   logic [1:0]        overflow_count_ff, overflow_count_in;
   logic [31:0]       frame_word_ff, frame_word_in;
   logic              edge_rising_ff, edge_rising_in;
   logic              held_flag_ff, held_flag_in;

   logic          ready, rep, rel;
   logic [CW-1:0] d;
   logic          mark_ok, space_ok, period_bad, bit_one, rspace_ok, burst_ok;
   logic          frame_done;
   logic [31:0]   shift_next;
   logic [8:0]    csum;

   assign d          = CW'(duration);
   assign mark_ok    = (d > CW'(cfg.leader_mark_min)) && (d < CW'(cfg.leader_mark_max));
   assign space_ok   = (d > CW'(cfg.leader_space_min)) && (d < CW'(cfg.leader_space_max));
   assign period_bad = (d < CW'(cfg.bit_period_min)) || (d > CW'(cfg.bit_period_max));
   assign bit_one    = d > CW'(cfg.one_threshold);
   assign rspace_ok  = (d > CW'(REP_SPACE_MIN)) && (d < CW'(REP_SPACE_MAX));
   assign burst_ok   = (d > CW'(REP_BURST_MIN)) && (d < CW'(REP_BURST_MAX));
   assign frame_done = bit_count_ff[BCNT_W-1];   // count reached 32
   assign shift_next = {shift_word_ff[30:0], bit_one};
   assign csum       = {1'b0, shift_next[15:8]} + {1'b0, shift_next[7:0]};

   always_comb begin
      leader_phase_in   = leader_phase_ff;
      in_data_in        = in_data_ff;
      bit_count_in      = bit_count_ff;
      shift_word_in     = shift_word_ff;
      repeat_phase_in   = repeat_phase_ff;
      overflow_count_in = overflow_count_ff;
      frame_word_in     = frame_word_ff;
      edge_rising_in    = edge_rising_ff;
      held_flag_in      = held_flag_ff;
      ready             = 1'b0;
      rep               = 1'b0;
      rel               = 1'b0;

      if (step) begin
         if (cmd == CMD_OVERFLOW) begin
            if (overflow_count_ff < cfg.timeout_ticks) begin
               overflow_count_in = overflow_count_ff + 2'd1;
            end else if (frame_done) begin
               leader_phase_in   = PH_IDLE;
               in_data_in        = 1'b0;
               repeat_phase_in   = PH_IDLE;
               overflow_count_in = '0;
               bit_count_in      = '0;
               held_flag_in      = 1'b0;
               rel               = 1'b1;
            end
         end else if (!in_data_ff) begin
            case (leader_phase_ff)
               PH_IDLE: begin
                  edge_rising_in  = 1'b1;
                  leader_phase_in = PH_MARK;
               end
               PH_MARK: begin
                  edge_rising_in  = 1'b0;
                  leader_phase_in = mark_ok ? PH_SPACE : PH_IDLE;
               end
               PH_SPACE: begin
                  if (space_ok) begin
                     in_data_in = 1'b1;
                  end else begin
                     leader_phase_in = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end else if (!frame_done) begin
            if (period_bad) begin
               leader_phase_in = PH_IDLE;
               in_data_in      = 1'b0;
               bit_count_in    = '0;
            end else begin
               shift_word_in = shift_next;
               bit_count_in  = bit_count_ff + 6'd1;
               if (bit_count_ff == BCNT_W'(FRAME_BITS - 1)) begin
                  frame_word_in = shift_next;
                  if (csum != CSUM_TARGET) begin
                     leader_phase_in = PH_IDLE;
                     in_data_in      = 1'b0;
                     bit_count_in    = '0;
                  end
               end
            end
         end else begin
            case (repeat_phase_ff)
               PH_IDLE: begin
                  edge_rising_in    = 1'b1;
                  ready             = 1'b1;
                  overflow_count_in = '0;
                  repeat_phase_in   = PH_MARK;
               end
               PH_MARK: begin
                  edge_rising_in = 1'b0;
                  if (mark_ok) begin
                     repeat_phase_in = PH_SPACE;
                  end else begin
                     leader_phase_in   = PH_IDLE;
                     in_data_in        = 1'b0;
                     repeat_phase_in   = PH_IDLE;
                     overflow_count_in = '0;
                     bit_count_in      = '0;
                  end
               end
               PH_SPACE: begin
                  if (rspace_ok) begin
                     edge_rising_in  = 1'b1;
                     repeat_phase_in = PH_BURST;
                  end else begin
                     leader_phase_in   = PH_IDLE;
                     in_data_in        = 1'b0;
                     repeat_phase_in   = PH_IDLE;
                     overflow_count_in = '0;
                     bit_count_in      = '0;
                  end
               end
               default: begin
                  edge_rising_in  = 1'b0;
                  repeat_phase_in = PH_IDLE;
                  if (burst_ok) begin
                     rep               = 1'b1;
                     overflow_count_in = '0;
                     held_flag_in      = 1'b1;
                  end else begin
                     leader_phase_in   = PH_IDLE;
                     in_data_in        = 1'b0;
                     overflow_count_in = '0;
                     bit_count_in      = '0;
                  end
               end
            endcase
         end
      end
   end

   // result reflects the state after this beat
   always_comb begin
      res.capture_rising   = edge_rising_in;
      res.frame_ready      = ready;
      res.repeat_seen      = rep;
      res.released         = rel;
      res.key_held         = held_flag_in;
      res.address_byte     = frame_word_in[31:24];
      res.address_inv_byte = frame_word_in[23:16];
      res.command_byte     = frame_word_in[15:8];
      res.command_inv_byte = frame_word_in[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_phase_ff   <= PH_IDLE;
         in_data_ff        <= 1'b0;
         bit_count_ff      <= '0;
         shift_word_ff     <= '0;
         repeat_phase_ff   <= PH_IDLE;
         overflow_count_ff <= '0;
         frame_word_ff     <= '0;
         edge_rising_ff    <= 1'b0;
         held_flag_ff      <= 1'b0;
      end else begin
         leader_phase_ff   <= leader_phase_in;
         in_data_ff        <= in_data_in;
         bit_count_ff      <= bit_count_in;
         shift_word_ff     <= shift_word_in;
         repeat_phase_ff   <= repeat_phase_in;
         overflow_count_ff <= overflow_count_in;
         frame_word_ff     <= frame_word_in;
         edge_rising_ff    <= edge_rising_in;
         held_flag_ff      <= held_flag_in;
      end
   end

`ifndef SYNTHESIS
   a_bcnt_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BCNT_W'(FRAME_BITS))
      else $error("bit count past frame length");

   a_bcnt_idle: assert property (@(posedge clock) disable iff (reset)
      !in_data_ff |-> bit_count_ff == '0)
      else $error("bit count live outside data phase");

   a_rep_after_frame: assert property (@(posedge clock) disable iff (reset)
      !frame_done |-> repeat_phase_ff == PH_IDLE)
      else $error("repeat sequence before a complete frame");

   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ready, rep, rel}))
      else $error("more than one event pulse in a beat");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      rel |=> !held_flag_ff && !in_data_ff && bit_count_ff == '0)
      else $error("release left decode state behind");
`endif

endmodule

// ===== design/nec_ir_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// Path: a request beat is held in the input register, then its result moves
//   into the result register, which offers it; a stalled response holds both.
// Throughput: one beat per cycle unless the response stalls; one-pass decode.
// Reset: synchronous; clears frame state and pipeline valids, loads the
//   register defaults. No clearing pass, ready the cycle after reset.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core
   import nirfd_pkg::*;
#(
   parameter int DURATION_BITS = DURATION_BITS_DEF
)
(
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = duration; tuser = cmd
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((DURATION_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tuser,
   // response tdata, low bit up: capture_rising, frame_ready, repeat_seen,
   // released, key_held, address_byte, address_inv_byte, command_byte,
   // command_inv_byte, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_TDATA_W-1:0]            rsp_tdata,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]             csr_paddr,
   input  logic [CSR_DATA_W-1:0]             csr_pwdata,
   output logic [CSR_DATA_W-1:0]             csr_prdata,
   output logic                              csr_pready
);

   cfg_type                  cfg;
   res_type                  res;
   logic                     in_vld_ff, in_vld_in;
   logic                     cmd_ff;
   logic [DURATION_BITS-1:0] dur_ff;
   logic                     rsp_vld_ff, rsp_vld_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;
   logic                     req_beat, step;

   // step: the held beat moves into the result register
   assign step       = in_vld_ff & (~rsp_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | step;
   assign req_beat   = req_tvalid & req_tready;
   assign in_vld_in  = req_beat | (in_vld_ff & ~step);
   assign rsp_vld_in = step | (rsp_vld_ff & ~rsp_tready);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   nirfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nirfd_decode #(
      .DURATION_BITS (DURATION_BITS)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (step),
      .cmd      (cmd_ff),
      .duration (dur_ff),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff <= req_tuser;
         dur_ff <= req_tdata[DURATION_BITS-1:0];
      end
      if (step) begin
         rsp_data_ff <= RSP_TDATA_W'(res);
      end
   end

endmodule
